// ===== hw/rtl/cbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // bus access kinds carried in tuser
    typedef enum logic [1:0] {
        FUNC_CPU_READ  = 2'd0,
        FUNC_CPU_WRITE = 2'd1,
        FUNC_PPU       = 2'd2
    } func_t;

    // register and window addresses
    localparam logic [15:0] ADDR_CHR_PRG     = 16'h5000;
    localparam logic [15:0] ADDR_TOGGLE_SET  = 16'h5100;
    localparam logic [15:0] ADDR_TOGGLE_FLIP = 16'h5101;
    localparam logic [15:0] ADDR_PRG_HIGH    = 16'h5200;
    localparam logic [15:0] ADDR_MODE        = 16'h5300;
    localparam logic [15:0] ADDR_STATUS_A    = 16'h5500;
    localparam logic [15:0] ADDR_STATUS_B    = 16'h5501;
    localparam logic [15:0] ADDR_WRAM_LO     = 16'h6000;
    localparam logic [15:0] ADDR_WRAM_HI     = 16'h7FFF;
    localparam logic [15:0] ADDR_SWAP_LO     = 16'h5000;
    localparam logic [15:0] ADDR_SWAP_HI     = 16'h5200;

    // offset bits inside the 8 KiB work ram window
    localparam int unsigned WRAM_OFFSET_W = 13;

    // program bank bits forced on outside extended mode
    localparam logic [5:0] PRG_FORCE_MASK = 6'h03;

    // one accepted bus beat
    typedef struct packed {
        logic        valid;
        func_t       func;
        logic [15:0] address;
        logic [7:0]  data;
    } bus_beat_t;

    // bank mapping after a beat
    typedef struct packed {
        logic       chr_high_bank;
        logic       chr_low_bank;
        logic [5:0] prg_bank;
    } bank_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper_163_core.sv =====
// throughput: one bus beat per cycle unless the output stalls the result stage
// the work ram read port is registered; it feeds a result stage, then an output
// register, and an accepted bus beat passes through both in that order
// reset: aresetn (sync, active low) clears all mapper registers, high half bank to 1
// work ram contents are not cleared and no clearing pass runs
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_163_core #(
    parameter int unsigned WORK_RAM_BYTES = 8192
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_data[7:0], prg_bank[13:8],
                                        // chr_low_bank[14], chr_high_bank[15]
);

    cbm_pkg::bus_beat_t    beat;
    cbm_pkg::bank_status_t status_next;
    logic [7:0]            reg_rdata;
    logic [7:0]            ram_rdata;
    logic                  accept;
    logic                  in_wram;
    logic                  ram_wr;
    logic                  ram_rd;
    logic                  st1_advance;

    logic                  st1_valid_reg, st1_valid_next;
    logic                  st1_ram_sel_reg;
    logic [7:0]            st1_rd_reg;
    cbm_pkg::bank_status_t st1_status_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [15:0]           m_tdata_reg;
    logic [7:0]            st1_read_data;

    // handshake and beat decode
    assign st1_advance = !m_valid_reg || m_tready;
    assign s_tready    = !st1_valid_reg || st1_advance;
    assign accept      = s_tvalid && s_tready;

    assign beat.valid   = accept;
    assign beat.func    = cbm_pkg::func_t'(s_tuser);
    assign beat.address = s_tdata[15:0];
    assign beat.data    = s_tdata[23:16];

    assign in_wram = (beat.address >= cbm_pkg::ADDR_WRAM_LO)
                  && (beat.address <= cbm_pkg::ADDR_WRAM_HI);
    assign ram_wr  = accept && in_wram && (beat.func == cbm_pkg::FUNC_CPU_WRITE);
    assign ram_rd  = accept && in_wram && (beat.func == cbm_pkg::FUNC_CPU_READ);

    cbm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat        (beat),
        .status_next (status_next),
        .reg_rdata   (reg_rdata)
    );

    cbm_wram #(
        .WORK_RAM_BYTES (WORK_RAM_BYTES)
    ) u_wram (
        .aclk   (aclk),
        .wr_en  (ram_wr),
        .rd_en  (ram_rd),
        .offset (beat.address[cbm_pkg::WRAM_OFFSET_W-1:0]),
        .wdata  (beat.data),
        .rdata  (ram_rdata)
    );

    // result stage valid tracking
    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_advance) begin
            st1_valid_next = 1'b0;
        end
    end

    // output register valid tracking
    always_comb begin
        m_valid_next = m_valid_reg;
        if (st1_valid_reg && st1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign st1_read_data = st1_ram_sel_reg ? ram_rdata : st1_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload of result stage and output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_ram_sel_reg <= ram_rd;
            st1_rd_reg      <= reg_rdata;
            st1_status_reg  <= status_next;
        end
        if (st1_valid_reg && st1_advance) begin
            m_tdata_reg <= {st1_status_reg.chr_high_bank, st1_status_reg.chr_low_bank,
                            st1_status_reg.prg_bank, st1_read_data};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // a stalled result stage must block new beats so held ram data survives
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while result stage stalled");

    // every accepted beat lands in the result stage
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st1_valid_reg)
        else $error("accepted beat lost before result stage");

    // the high half bank never drops to bank 0
    a_high_bank_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15])
        else $error("high half character bank cleared");

endmodule

`default_nettype wire

// ===== hw/rtl/cbm_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbm_regs (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cbm_pkg::bus_beat_t    beat,
    output cbm_pkg::bank_status_t      status_next,
    output logic [7:0]                 reg_rdata
);

    logic [5:0] prg_bits_reg, prg_bits_next;
    logic       split_reg, split_next;
    logic       toggle_reg, toggle_next;
    logic       swap_reg, swap_next;
    logic       ext_reg, ext_next;
    logic       a9_reg, a9_next;
    logic       a13_reg, a13_next;
    logic       low_reg, low_next;
    logic       high_reg, high_next;

    logic [7:0] wdata;
    logic       in_swap_range;
    logic       a13;

    // character half banks after a recompute
    function automatic logic [1:0] chr_update(input logic split, input logic a9,
                                              input logic low, input logic high);
        logic [1:0] res;
        res = {low, high};
        if (!split) begin
            res = 2'b01;
        end else if (a9) begin
            res = {low, 1'b1};
        end else begin
            res = {1'b1, high};
        end
        return res;
    endfunction

    assign in_swap_range = (beat.address >= cbm_pkg::ADDR_SWAP_LO)
                        && (beat.address <= cbm_pkg::ADDR_SWAP_HI);
    assign a13 = beat.address[13];

    // optional swap of the two low data bits
    always_comb begin
        wdata = beat.data;
        if (swap_reg && in_swap_range) begin
            wdata = {beat.data[7:2], beat.data[0], beat.data[1]};
        end
    end

    // register update for one beat
    always_comb begin
        prg_bits_next = prg_bits_reg;
        split_next    = split_reg;
        toggle_next   = toggle_reg;
        swap_next     = swap_reg;
        ext_next      = ext_reg;
        a9_next       = a9_reg;
        a13_next      = a13_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        if (beat.valid) begin
            unique case (beat.func)
                cbm_pkg::FUNC_CPU_WRITE: begin
                    unique case (beat.address)
                        cbm_pkg::ADDR_CHR_PRG: begin
                            split_next = wdata[7];
                            prg_bits_next = {prg_bits_reg[5:4], wdata[3:0]};
                            {low_next, high_next} = chr_update(wdata[7], a9_reg,
                                                               low_reg, high_reg);
                        end
                        cbm_pkg::ADDR_TOGGLE_SET: begin
                            toggle_next = wdata[2];
                        end
                        cbm_pkg::ADDR_TOGGLE_FLIP: begin
                            toggle_next = toggle_reg ^ wdata[0];
                        end
                        cbm_pkg::ADDR_PRG_HIGH: begin
                            prg_bits_next = {wdata[1:0], prg_bits_reg[3:0]};
                        end
                        cbm_pkg::ADDR_MODE: begin
                            swap_next = wdata[0];
                            ext_next  = wdata[2];
                        end
                        default: begin
                        end
                    endcase
                end
                cbm_pkg::FUNC_PPU: begin
                    // rising edge of ppu address bit 13 latches bit 9
                    if (!a13_reg && a13) begin
                        a9_next = beat.address[9];
                        {low_next, high_next} = chr_update(split_reg, beat.address[9],
                                                           low_reg, high_reg);
                    end
                    a13_next = a13;
                end
                default: begin
                end
            endcase
        end
    end

    // mapping seen after this beat
    always_comb begin
        status_next.prg_bank      = ext_next ? prg_bits_next
                                             : (prg_bits_next | cbm_pkg::PRG_FORCE_MASK);
        status_next.chr_low_bank  = low_next;
        status_next.chr_high_bank = high_next;
    end

    // status register read
    always_comb begin
        reg_rdata = 8'h00;
        if (beat.func == cbm_pkg::FUNC_CPU_READ
            && (beat.address == cbm_pkg::ADDR_STATUS_A
                || beat.address == cbm_pkg::ADDR_STATUS_B)) begin
            reg_rdata = {5'b00000, ~toggle_reg, 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_bits_reg <= '0;
            split_reg    <= 1'b0;
            toggle_reg   <= 1'b0;
            swap_reg     <= 1'b0;
            ext_reg      <= 1'b0;
            a9_reg       <= 1'b0;
            a13_reg      <= 1'b0;
            low_reg      <= 1'b0;
            high_reg     <= 1'b1;
        end else begin
            prg_bits_reg <= prg_bits_next;
            split_reg    <= split_next;
            toggle_reg   <= toggle_next;
            swap_reg     <= swap_next;
            ext_reg      <= ext_next;
            a9_reg       <= a9_next;
            a13_reg      <= a13_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cbm_wram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbm_wram #(
    parameter int unsigned WORK_RAM_BYTES = 8192
) (
    input  wire logic                                aclk,
    input  wire logic                                wr_en,
    input  wire logic                                rd_en,
    input  wire logic [cbm_pkg::WRAM_OFFSET_W-1:0]   offset,
    input  wire logic [7:0]                          wdata,
    output logic [7:0]                               rdata
);

    localparam int unsigned IDX_W = (WORK_RAM_BYTES > 1) ? $clog2(WORK_RAM_BYTES) : 1;
    localparam logic [15:0] MOD_X4 = 16'(4 * WORK_RAM_BYTES);
    localparam logic [15:0] MOD_X2 = 16'(2 * WORK_RAM_BYTES);
    localparam logic [15:0] MOD_X1 = 16'(WORK_RAM_BYTES);

    logic [7:0]       mem [WORK_RAM_BYTES];
    logic [7:0]       rdata_reg;
    logic [15:0]      red_a;
    logic [15:0]      red_b;
    logic [15:0]      red_c;
    logic [15:0]      red_d;
    logic [IDX_W-1:0] idx;

    // mirror the window onto the ram size: offset < 8 * size, three restoring steps
    always_comb begin
        red_a = {3'b000, offset};
        red_b = (red_a >= MOD_X4) ? red_a - MOD_X4 : red_a;
        red_c = (red_b >= MOD_X2) ? red_b - MOD_X2 : red_b;
        red_d = (red_c >= MOD_X1) ? red_c - MOD_X1 : red_c;
    end

    assign idx = red_d[IDX_W-1:0];

    // single port array, read data registered and held between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
